// ===== rtl/core/psf_pkg.sv =====
// Shared constants, register codes and character-class functions for the printable string finder.
package psf_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 25;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LEN     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_STRINGS = 2'd2;

    localparam int MIN_LEN_W = 13;
    localparam int CAP_W     = 25;
    localparam int COUNT_W   = 20;
    localparam int USED_W    = 32;

    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET     = 13'd4;
    localparam logic [MIN_LEN_W-1:0] MIN_LEN_DEFAULT   = 13'd4;
    localparam logic [CAP_W-1:0]     CAP_RESET         = 25'd0;
    localparam logic [CAP_W-1:0]     CAP_CEILING       = 25'h1000000;
    localparam logic [COUNT_W-1:0]   MAX_STRINGS_RESET = 20'd100000;

    localparam logic [7:0]  CHAR_SPACE = 8'h20;
    localparam logic [7:0]  CHAR_TILDE = 8'h7E;
    localparam logic [7:0]  CHAR_TAB   = 8'h09;
    localparam logic [7:0]  CHAR_LF    = 8'h0A;
    localparam logic [7:0]  CHAR_CR    = 8'h0D;
    localparam logic [15:0] WIDE_HIGH_LO = 16'h00A0;
    localparam logic [15:0] WIDE_HIGH_HI = 16'hFFFE;

    function automatic logic ascii_printable(input logic [7:0] c);
        return ((c >= CHAR_SPACE) && (c <= CHAR_TILDE)) ||
               (c == CHAR_TAB) || (c == CHAR_LF) || (c == CHAR_CR);
    endfunction

    function automatic logic wide_printable(input logic [15:0] c);
        return ((c >= {8'h00, CHAR_SPACE}) && (c <= {8'h00, CHAR_TILDE})) ||
               ((c >= WIDE_HIGH_LO) && (c <= WIDE_HIGH_HI)) ||
               (c == {8'h00, CHAR_TAB}) || (c == {8'h00, CHAR_LF}) ||
               (c == {8'h00, CHAR_CR});
    endfunction

endpackage

// ===== rtl/core/printable_string_finder.sv =====
// Streaming finder of printable ASCII and UTF-16 runs that emits string descriptors.
// A byte accepted into the input stage is decided when the stage fires, and its
// descriptors are written into the output queue and presented from there.
// Throughput: one byte per cycle while each byte closes at most one string; a byte that
// closes both runs puts two descriptors into the four-entry output queue, which drains
// one per cycle while out_stall is low. The stage holds with under two free entries.
// Reset clears all run state, counters, the queue and the registers to their defaults.
module printable_string_finder #(
    parameter int MAX_RUN_CHARS = 4096,
    parameter int ADDRESS_BITS  = 47,
    parameter int HEADER_BYTES  = 11
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [psf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [psf_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          byte_value,
    input  logic [ADDRESS_BITS-1:0]             byte_address,
    input  logic                                chunk_end,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ADDRESS_BITS-1:0]             string_address,
    output logic [$clog2(2*MAX_RUN_CHARS+1)-1:0] byte_length,
    output logic                                is_wide,
    output logic [psf_pkg::CAP_W-1:0]           record_offset,
    output logic [psf_pkg::COUNT_W-1:0]         string_index,
    output logic                                last
);

    localparam int RUN_W   = $clog2(MAX_RUN_CHARS + 2);
    localparam int LEN_W   = $clog2(2*MAX_RUN_CHARS + 1);
    localparam int CMP_W   = (RUN_W > psf_pkg::MIN_LEN_W) ? RUN_W : psf_pkg::MIN_LEN_W;
    localparam int SUM_W   = psf_pkg::USED_W + 1;
    localparam int DEPTH   = 4;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    localparam logic [RUN_W-1:0] RUN_MAX  = RUN_W'(MAX_RUN_CHARS);
    localparam logic [RUN_W-1:0] RUN_SAT  = RUN_W'(MAX_RUN_CHARS + 1);

    typedef struct packed {
        logic [ADDRESS_BITS-1:0]      addr;
        logic [LEN_W-1:0]             blen;
        logic                         wide;
        logic [psf_pkg::CAP_W-1:0]    offset;
        logic [psf_pkg::COUNT_W-1:0]  index;
        logic                         last;
    } desc_t;

    // Configuration registers.
    logic [psf_pkg::MIN_LEN_W-1:0] min_len_reg;
    logic [psf_pkg::CAP_W-1:0]     capacity_reg;
    logic [psf_pkg::COUNT_W-1:0]   max_strings_reg;

    // Input stage.
    logic                          stage_valid_reg;
    logic                          stage_valid_next;
    logic [7:0]                    s_value_reg;
    logic [ADDRESS_BITS-1:0]       s_addr_reg;
    logic                          s_end_reg;
    logic                          accept;
    logic                          fire;

    // Detector state.
    logic [RUN_W-1:0]              a_len_reg, a_len_next;
    logic [ADDRESS_BITS-1:0]       a_start_reg, a_start_next;
    logic                          a_stop_reg, a_stop_next;
    logic [RUN_W-1:0]              w_len_reg, w_len_next;
    logic [ADDRESS_BITS-1:0]       w_start_reg, w_start_next;
    logic                          w_stop_reg, w_stop_next;
    logic [7:0]                    held_reg, held_next;
    logic                          phase_reg, phase_next;
    logic [psf_pkg::COUNT_W-1:0]   found_reg, found_next;
    logic [psf_pkg::USED_W-1:0]    used_reg, used_next;

    // Decision logic.
    logic [psf_pkg::MIN_LEN_W-1:0] min_len_eff;
    logic [psf_pkg::CAP_W-1:0]     cap_eff;
    logic                          a_print;
    logic [RUN_W-1:0]              a_len_cur;
    logic [ADDRESS_BITS-1:0]       a_start_cur;
    logic                          a_close;
    logic                          a_qual;
    logic [LEN_W-1:0]              a_blen;
    logic [SUM_W-1:0]              a_sum;
    logic                          a_refuse;
    logic                          a_emit;
    logic [psf_pkg::USED_W-1:0]    used_mid;
    logic [psf_pkg::COUNT_W-1:0]   found_mid;
    logic                          w_print;
    logic [RUN_W-1:0]              w_len_cur;
    logic [ADDRESS_BITS-1:0]       w_start_cur;
    logic                          w_close;
    logic                          w_qual;
    logic [LEN_W-1:0]              w_blen;
    logic [SUM_W-1:0]              w_sum;
    logic                          w_refuse;
    logic                          w_emit;
    desc_t                         a_desc;
    desc_t                         w_desc;
    desc_t                         push0;
    logic [1:0]                    push_cnt;

    // Output queue.
    desc_t                         fifo_mem [DEPTH];
    logic [PTR_W-1:0]              wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]              count_reg;
    logic                          pop;
    desc_t                         head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg     <= psf_pkg::MIN_LEN_RESET;
            capacity_reg    <= psf_pkg::CAP_RESET;
            max_strings_reg <= psf_pkg::MAX_STRINGS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                psf_pkg::CFG_MIN_LEN:     min_len_reg     <= cfg_data[psf_pkg::MIN_LEN_W-1:0];
                psf_pkg::CFG_CAPACITY:    capacity_reg    <= cfg_data[psf_pkg::CAP_W-1:0];
                psf_pkg::CFG_MAX_STRINGS: max_strings_reg <= cfg_data[psf_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign fire     = stage_valid_reg && (count_reg <= CNT_W'(DEPTH - 2));
    assign in_stall = stage_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (fire)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_value_reg <= byte_value;
            s_addr_reg  <= byte_address;
            s_end_reg   <= chunk_end;
        end
    end

    assign min_len_eff = (min_len_reg == '0) ? psf_pkg::MIN_LEN_DEFAULT : min_len_reg;
    assign cap_eff     = (capacity_reg > psf_pkg::CAP_CEILING) ? psf_pkg::CAP_CEILING
                                                               : capacity_reg;

    always_comb
    begin
        // ASCII detector.
        a_print     = psf_pkg::ascii_printable(s_value_reg);
        a_len_cur   = a_len_reg;
        a_start_cur = a_start_reg;
        a_close     = 1'b0;
        if (!a_stop_reg)
        begin
            if (a_print)
            begin
                if (a_len_reg == '0)
                begin
                    a_start_cur = s_addr_reg;
                end
                a_len_cur = (a_len_reg < RUN_SAT) ? a_len_reg + 1'b1 : a_len_reg;
            end
            a_close = !a_print || s_end_reg;
        end
        a_qual = a_close && (a_len_cur != '0) &&
                 (CMP_W'(a_len_cur) >= CMP_W'(min_len_eff)) && (a_len_cur <= RUN_MAX);
        a_blen   = LEN_W'(a_len_cur);
        a_sum    = SUM_W'(used_reg) + SUM_W'(HEADER_BYTES) + SUM_W'(a_blen);
        a_refuse = (found_reg >= max_strings_reg) ||
                   ((cap_eff != '0) && (a_sum > SUM_W'(cap_eff)));
        a_emit   = a_qual && !a_refuse;

        used_mid  = used_reg;
        found_mid = found_reg;
        if (a_emit)
        begin
            used_mid  = a_sum[SUM_W-1] ? '1 : a_sum[psf_pkg::USED_W-1:0];
            found_mid = (found_reg == '1) ? found_reg : found_reg + 1'b1;
        end

        // Wide detector.
        held_next   = held_reg;
        w_print     = psf_pkg::wide_printable({s_value_reg, held_reg});
        w_len_cur   = w_len_reg;
        w_start_cur = w_start_reg;
        w_close     = 1'b0;
        if (!w_stop_reg)
        begin
            if (!phase_reg)
            begin
                held_next = s_value_reg;
                if (w_len_reg == '0)
                begin
                    w_start_cur = s_addr_reg;
                end
                w_close = s_end_reg;
            end
            else
            begin
                if (w_print)
                begin
                    w_len_cur = (w_len_reg < RUN_SAT) ? w_len_reg + 1'b1 : w_len_reg;
                end
                w_close = !w_print || s_end_reg;
            end
        end
        w_qual = w_close && (w_len_cur != '0) &&
                 (CMP_W'(w_len_cur) >= CMP_W'(min_len_eff)) && (w_len_cur <= RUN_MAX);
        w_blen   = LEN_W'({w_len_cur, 1'b0});
        w_sum    = SUM_W'(used_mid) + SUM_W'(HEADER_BYTES) + SUM_W'(w_blen);
        w_refuse = (found_mid >= max_strings_reg) ||
                   ((cap_eff != '0) && (w_sum > SUM_W'(cap_eff)));
        w_emit   = w_qual && !w_refuse;

        used_next  = used_mid;
        found_next = found_mid;
        if (w_emit)
        begin
            used_next  = w_sum[SUM_W-1] ? '1 : w_sum[psf_pkg::USED_W-1:0];
            found_next = (found_mid == '1) ? found_mid : found_mid + 1'b1;
        end

        a_len_next   = a_close ? '0 : a_len_cur;
        a_start_next = a_start_cur;
        a_stop_next  = a_stop_reg || (a_qual && a_refuse);
        w_len_next   = w_close ? '0 : w_len_cur;
        w_start_next = w_start_cur;
        w_stop_next  = w_stop_reg || (w_qual && w_refuse);
        phase_next   = !phase_reg;
        if (s_end_reg)
        begin
            a_len_next  = '0;
            w_len_next  = '0;
            a_stop_next = 1'b0;
            w_stop_next = 1'b0;
            phase_next  = 1'b0;
        end

        a_desc.addr   = a_start_cur;
        a_desc.blen   = a_blen;
        a_desc.wide   = 1'b0;
        a_desc.offset = used_reg[psf_pkg::CAP_W-1:0];
        a_desc.index  = found_reg;
        a_desc.last   = !w_emit;

        w_desc.addr   = w_start_cur;
        w_desc.blen   = w_blen;
        w_desc.wide   = 1'b1;
        w_desc.offset = used_mid[psf_pkg::CAP_W-1:0];
        w_desc.index  = found_mid;
        w_desc.last   = 1'b1;

        push0    = a_emit ? a_desc : w_desc;
        push_cnt = {1'b0, a_emit} + {1'b0, w_emit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_len_reg   <= '0;
            a_start_reg <= '0;
            a_stop_reg  <= 1'b0;
            w_len_reg   <= '0;
            w_start_reg <= '0;
            w_stop_reg  <= 1'b0;
            held_reg    <= '0;
            phase_reg   <= 1'b0;
            found_reg   <= '0;
            used_reg    <= '0;
        end
        else if (fire)
        begin
            a_len_reg   <= a_len_next;
            a_start_reg <= a_start_next;
            a_stop_reg  <= a_stop_next;
            w_len_reg   <= w_len_next;
            w_start_reg <= w_start_next;
            w_stop_reg  <= w_stop_next;
            held_reg    <= held_next;
            phase_reg   <= phase_next;
            found_reg   <= found_next;
            used_reg    <= used_next;
        end
    end

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign head      = fifo_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (fire && (push_cnt != 2'd0))
        begin
            fifo_mem[wr_ptr_reg] <= push0;
        end
        if (fire && (push_cnt == 2'd2))
        begin
            fifo_mem[wr_ptr_reg + 1'b1] <= w_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_cnt);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (fire ? CNT_W'(push_cnt) : CNT_W'(0)) -
                         (pop ? CNT_W'(1) : CNT_W'(0));
        end
    end

    assign string_address = head.addr;
    assign byte_length    = head.blen;
    assign is_wide        = head.wide;
    assign record_offset  = head.offset;
    assign string_index   = head.index;
    assign last           = head.last;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("Output queue count exceeds its depth.");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> !is_wide)
        else $error("A wide descriptor is followed by another from the same byte.");

    a_pair_present: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (count_reg >= CNT_W'(2)))
        else $error("The partner of a non-final descriptor is missing from the queue.");

    a_chunk_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s_end_reg) |=> (!phase_reg && !a_stop_reg && !w_stop_reg &&
                                 (a_len_reg == '0) && (w_len_reg == '0)))
        else $error("Detectors were not restarted after a chunk end.");

    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (a_len_reg <= RUN_SAT) && (w_len_reg <= RUN_SAT))
        else $error("A run length counter passed its saturation value.");

endmodule

// ===== bench/printable_string_finder_tb.sv =====
// Self-checking testbench for the printable string finder.
`timescale 1ns / 100ps

module printable_string_finder_tb;

    localparam int RUN_LIMIT    = 4096;
    localparam int HEADER_SIZE  = 11;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int SHOWN_ERRORS = 10;
    localparam int DRAIN_LIMIT  = 5000;

    typedef struct packed {
        logic [46:0] address;
        logic [13:0] length;
        logic        wide;
        logic [24:0] offset;
        logic [19:0] index;
        logic        last;
    } descriptor_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [psf_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [psf_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic [7:0]                      byte_value;
    logic [46:0]                     byte_address;
    logic                            chunk_end;
    logic                            out_valid;
    logic                            out_stall;
    logic [46:0]                     string_address;
    logic [13:0]                     byte_length;
    logic                            is_wide;
    logic [24:0]                     record_offset;
    logic [19:0]                     string_index;
    logic                            last;

    logic [12:0]  min_chars;
    logic [24:0]  capacity;
    logic [19:0]  count_limit;
    int unsigned  ascii_len;
    int unsigned  wide_len;
    logic [46:0]  ascii_start;
    logic [46:0]  wide_start;
    bit           ascii_halted;
    bit           wide_halted;
    logic [7:0]   low_byte;
    bit           odd_position;
    logic [19:0]  strings_reported;
    logic [31:0]  record_bytes;

    descriptor_t  expected_descs[$];
    descriptor_t  byte_descs[$];
    logic [7:0]   chunk_bytes[$];
    logic [46:0]  next_address;
    int           items_sent;
    int           error_count;
    int           cycle_count;
    bit           idle_on;
    int           hold_request;
    int           hold_left;
    int           stall_left;
    descriptor_t  seen_desc;
    descriptor_t  wanted_desc;

    printable_string_finder i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .byte_value     (byte_value),
        .byte_address   (byte_address),
        .chunk_end      (chunk_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .string_address (string_address),
        .byte_length    (byte_length),
        .is_wide        (is_wide),
        .record_offset  (record_offset),
        .string_index   (string_index),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic bit is_text_char(logic [7:0] c);
        return (c >= 8'h20 && c <= 8'h7E) || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic bit is_wide_char(logic [15:0] c);
        return (c >= 16'h0020 && c <= 16'h007E) || (c >= 16'h00A0 && c <= 16'hFFFE) ||
               c == 16'h0009 || c == 16'h000A || c == 16'h000D;
    endfunction

    function automatic bit record_string(logic [46:0] start, int unsigned nbytes, bit wide);
        logic [24:0]      budget;
        longint unsigned  entry;
        longint unsigned  used;
        descriptor_t      d;
        budget = (capacity > psf_pkg::CAP_CEILING) ? psf_pkg::CAP_CEILING : capacity;
        entry  = HEADER_SIZE + nbytes;
        used   = record_bytes;
        if (strings_reported >= count_limit)
            return 1'b0;
        if (budget != 0 && used + entry > budget)
            return 1'b0;
        d.address = start;
        d.length  = 14'(nbytes);
        d.wide    = wide;
        d.offset  = record_bytes[24:0];
        d.index   = strings_reported;
        d.last    = 1'b0;
        byte_descs.push_back(d);
        record_bytes = (used + entry > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(used + entry);
        if (strings_reported != 20'hFFFFF)
            strings_reported++;
        return 1'b1;
    endfunction

    function automatic bit close_run(int unsigned chars, logic [46:0] start, bit wide);
        int unsigned threshold;
        threshold = (min_chars == 0) ? 4 : min_chars;
        if (chars == 0 || chars < threshold || chars > RUN_LIMIT)
            return 1'b1;
        return record_string(start, wide ? chars * 2 : chars, wide);
    endfunction

    function automatic void predict_byte(logic [7:0] value, logic [46:0] address, bit ends);
        bit           text;
        descriptor_t  d;
        byte_descs.delete();
        if (!ascii_halted)
        begin
            text = is_text_char(value);
            if (text)
            begin
                if (ascii_len == 0)
                    ascii_start = address;
                if (ascii_len <= RUN_LIMIT)
                    ascii_len++;
            end
            if (!text || ends)
            begin
                if (!close_run(ascii_len, ascii_start, 1'b0))
                    ascii_halted = 1'b1;
                ascii_len = 0;
            end
        end
        if (!wide_halted)
        begin
            if (!odd_position)
            begin
                low_byte = value;
                if (wide_len == 0)
                    wide_start = address;
                if (ends)
                begin
                    if (!close_run(wide_len, wide_start, 1'b1))
                        wide_halted = 1'b1;
                    wide_len = 0;
                end
            end
            else
            begin
                text = is_wide_char({value, low_byte});
                if (text && wide_len <= RUN_LIMIT)
                    wide_len++;
                if (!text || ends)
                begin
                    if (!close_run(wide_len, wide_start, 1'b1))
                        wide_halted = 1'b1;
                    wide_len = 0;
                end
            end
        end
        odd_position = !odd_position;
        if (ends)
        begin
            ascii_len    = 0;
            wide_len     = 0;
            ascii_halted = 1'b0;
            wide_halted  = 1'b0;
            odd_position = 1'b0;
        end
        if (byte_descs.size() > 0)
        begin
            d = byte_descs.pop_back();
            d.last = 1'b1;
            byte_descs.push_back(d);
        end
        foreach (byte_descs[k])
            expected_descs.push_back(byte_descs[k]);
    endfunction

    function automatic logic [46:0] random_address();
        logic [63:0] r;
        r = {$urandom, $urandom};
        if ($urandom_range(0, 5) == 0)
            return 47'h7FFF_FFFF_FFFF - 47'($urandom_range(0, 40));
        return r[46:0];
    endfunction

    function automatic logic [7:0] text_byte();
        case ($urandom_range(0, 19))
            0:       return 8'h09;
            1:       return 8'h0A;
            2:       return 8'h0D;
            default: return 8'($urandom_range(8'h20, 8'h7E));
        endcase
    endfunction

    // Mostly printable ASCII runs and UTF-16 runs, usually aligned, broken up by noise bytes.
    function automatic void build_random_chunk();
        int          target;
        logic [15:0] wide_char;
        chunk_bytes.delete();
        target = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
        while (chunk_bytes.size() < target)
        begin
            case ($urandom_range(0, 5))
                0, 1:
                begin
                    repeat ($urandom_range(1, 12))
                        chunk_bytes.push_back(text_byte());
                end
                2, 3:
                begin
                    if (chunk_bytes.size() % 2 == 1 && $urandom_range(0, 3) != 0)
                        chunk_bytes.push_back(8'($urandom_range(0, 255)));
                    repeat ($urandom_range(1, 8))
                    begin
                        if ($urandom_range(0, 2) == 0)
                            wide_char = 16'($urandom_range(16'h00A0, 16'hFFFE));
                        else
                            wide_char = {8'h00, text_byte()};
                        chunk_bytes.push_back(wide_char[7:0]);
                        chunk_bytes.push_back(wide_char[15:8]);
                    end
                end
                4:
                begin
                    repeat ($urandom_range(1, 3))
                        chunk_bytes.push_back(8'($urandom_range(0, 255)));
                end
                default:
                begin
                    case ($urandom_range(0, 5))
                        0:       chunk_bytes.push_back(8'h00);
                        1:       chunk_bytes.push_back(8'h1F);
                        2:       chunk_bytes.push_back(8'h7F);
                        3:       chunk_bytes.push_back(8'h9F);
                        4:       chunk_bytes.push_back(8'hA0);
                        default: chunk_bytes.push_back(8'hFF);
                    endcase
                end
            endcase
        end
    endfunction

    task automatic wait_until_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_descs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [psf_pkg::CFG_INDEX_W-1:0] index,
                                  logic [psf_pkg::CFG_DATA_W-1:0] value);
        wait_until_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            psf_pkg::CFG_MIN_LEN:     min_chars   = value[12:0];
            psf_pkg::CFG_CAPACITY:    capacity    = value;
            psf_pkg::CFG_MAX_STRINGS: count_limit = value[19:0];
            default:                  ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_byte(logic [7:0] value, bit ends);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 9) == 0)
            gap = $urandom_range(1, 13);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        byte_value   <= value;
        byte_address <= next_address;
        chunk_end    <= ends;
        do @(posedge clk); while (in_stall);
        predict_byte(value, next_address, ends);
        next_address++;
        items_sent++;
    endtask

    task automatic send_chunk();
        next_address = random_address();
        foreach (chunk_bytes[k])
            send_byte(chunk_bytes[k], k == chunk_bytes.size() - 1);
    endtask

    task automatic send_random_chunks(int item_count);
        int first_item;
        first_item = items_sent;
        while (items_sent - first_item < item_count)
        begin
            build_random_chunk();
            send_chunk();
        end
    endtask

    task automatic test_directed_cases();
        chunk_bytes = {8'h20, 8'h7E, 8'h0A, 8'h0D, 8'h7F, 8'h41};
        send_chunk();
        chunk_bytes = {8'h41, 8'h00, 8'h42, 8'h00, 8'hA0, 8'h00, 8'hFE, 8'hFF};
        send_chunk();
        chunk_bytes = {8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68};
        send_chunk();
        chunk_bytes = {8'h9F, 8'h00, 8'hFF, 8'hFF, 8'h1F, 8'h09, 8'h43, 8'h00, 8'h44, 8'h00,
                       8'h45, 8'h00, 8'h46, 8'h00, 8'h47};
        send_chunk();
    endtask

    task automatic test_min_len_extremes();
        write_register(psf_pkg::CFG_MIN_LEN, 25'h1FFF);
        chunk_bytes = {8'h78, 8'h78, 8'h78, 8'h78, 8'h78, 8'h78};
        send_chunk();
        write_register(psf_pkg::CFG_MIN_LEN, 25'd0);
        chunk_bytes = {8'h61, 8'h62, 8'h63, 8'h64};
        send_chunk();
        write_register(psf_pkg::CFG_MIN_LEN, 25'd1);
        chunk_bytes = {8'h71};
        send_chunk();
    endtask

    task automatic test_count_limit();
        write_register(psf_pkg::CFG_MIN_LEN, 25'd1);
        write_register(psf_pkg::CFG_MAX_STRINGS, 25'(strings_reported + 20'd2));
        send_random_chunks(80);
        write_register(psf_pkg::CFG_MAX_STRINGS, 25'd0);
        send_random_chunks(30);
        write_register(psf_pkg::CFG_MAX_STRINGS, 25'hFFFFF);
    endtask

    task automatic test_budget_limit();
        write_register(psf_pkg::CFG_CAPACITY, 25'(record_bytes + 32'd40));
        send_random_chunks(80);
        write_register(psf_pkg::CFG_CAPACITY, 25'd1);
        send_random_chunks(30);
        write_register(psf_pkg::CFG_CAPACITY, psf_pkg::CAP_CEILING);
        send_random_chunks(30);
        write_register(psf_pkg::CFG_CAPACITY, 25'h1FFFFFF);
        send_random_chunks(30);
        write_register(psf_pkg::CFG_CAPACITY, 25'd0);
    endtask

    task automatic test_random_traffic();
        write_register(psf_pkg::CFG_MIN_LEN, 25'd4);
        write_register(psf_pkg::CFG_MAX_STRINGS, 25'(psf_pkg::MAX_STRINGS_RESET));
        send_random_chunks(200);
        write_register(psf_pkg::CFG_MIN_LEN, 25'd1);
        send_random_chunks(200);
        write_register(psf_pkg::CFG_MIN_LEN, 25'd2);
        write_register(psf_pkg::CFG_CAPACITY, 25'h1FFFFFF);
        write_register(psf_pkg::CFG_MAX_STRINGS, 25'hFFFFF);
        send_random_chunks(200);
    endtask

    task automatic test_backpressure();
        write_register(psf_pkg::CFG_MIN_LEN, 25'd1);
        hold_request = 300;
        send_random_chunks(200);
    endtask

    task automatic test_steady_stream();
        write_register(psf_pkg::CFG_MIN_LEN, 25'd3);
        write_register(psf_pkg::CFG_CAPACITY, 25'd0);
        idle_on = 1'b0;
        send_random_chunks(200);
    endtask

    initial
    begin
        out_stall  = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 12);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_desc = {string_address, byte_length, is_wide, record_offset, string_index, last};
            if (expected_descs.size() == 0)
            begin
                error_count++;
                if (error_count <= SHOWN_ERRORS)
                    $display("unexpected transaction: %h %0d %0b %0d %0d %0b",
                             seen_desc.address, seen_desc.length, seen_desc.wide,
                             seen_desc.offset, seen_desc.index, seen_desc.last);
            end
            else
            begin
                wanted_desc = expected_descs.pop_front();
                if (seen_desc !== wanted_desc)
                begin
                    error_count++;
                    if (error_count <= SHOWN_ERRORS)
                    begin
                        $display("mismatch: expected %h %0d %0b %0d %0d %0b",
                                 wanted_desc.address, wanted_desc.length, wanted_desc.wide,
                                 wanted_desc.offset, wanted_desc.index, wanted_desc.last);
                        $display("          actual   %h %0d %0b %0d %0d %0b",
                                 seen_desc.address, seen_desc.length, seen_desc.wide,
                                 seen_desc.offset, seen_desc.index, seen_desc.last);
                    end
                end
            end
        end
    end

    initial
    begin
        int drain_cycles;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = psf_pkg::CFG_MIN_LEN;
        cfg_data     = '0;
        in_valid     = 1'b0;
        byte_value   = 8'h00;
        byte_address = '0;
        chunk_end    = 1'b0;
        min_chars        = psf_pkg::MIN_LEN_RESET;
        capacity         = psf_pkg::CAP_RESET;
        count_limit      = psf_pkg::MAX_STRINGS_RESET;
        ascii_len        = 0;
        wide_len         = 0;
        ascii_start      = '0;
        wide_start       = '0;
        ascii_halted     = 1'b0;
        wide_halted      = 1'b0;
        low_byte         = 8'h00;
        odd_position     = 1'b0;
        strings_reported = '0;
        record_bytes     = '0;
        next_address     = '0;
        items_sent       = 0;
        error_count      = 0;
        idle_on          = 1'b1;
        hold_request     = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_min_len_extremes();
        test_count_limit();
        test_budget_limit();
        test_random_traffic();
        test_backpressure();
        test_steady_stream();

        @(negedge clk);
        in_valid <= 1'b0;
        drain_cycles = 0;
        while (expected_descs.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (10) @(posedge clk);
        if (expected_descs.size() != 0)
        begin
            if (error_count < SHOWN_ERRORS)
                $display("missing transactions: %0d expected descriptors never arrived",
                         expected_descs.size());
            error_count += expected_descs.size();
        end
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== printable_string_finder.f =====
rtl/core/psf_pkg.sv
rtl/core/printable_string_finder.sv
bench/printable_string_finder_tb.sv
